// ===== sv/ble_pkg.sv =====
// Package with shared codes, state and command types of the bounded list engine.
package ble_pkg;

   // Command modes carried by an input item.
   localparam logic [2:0] MODE_ADD_FRONT = 3'd0;
   localparam logic [2:0] MODE_ADD_END   = 3'd1;
   localparam logic [2:0] MODE_REMOVE    = 3'd2;
   localparam logic [2:0] MODE_SORT      = 3'd3;
   localparam logic [2:0] MODE_ROT_LEFT  = 3'd4;
   localparam logic [2:0] MODE_ROT_RIGHT = 3'd5;
   localparam logic [2:0] MODE_DUMP      = 3'd6;
   localparam logic [2:0] MODE_DUMP_REV  = 3'd7;

   // Status codes reported with each result item.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_RM_RD,
      S_RM_WR,
      S_ROT_RD,
      S_ROT_WR,
      S_SRT_RDI,
      S_SRT_LDI,
      S_SRT_RDJ,
      S_SRT_CMP,
      S_SRT_WR1,
      S_SRT_WR2,
      S_DMP_RD,
      S_DMP_OUT,
      S_RESP
   } state_type;

   // Datapath commands, one per cycle.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_ADD_FRONT,
      OP_ADD_END,
      OP_SET_FULL,
      OP_SET_BAD,
      OP_RM_INIT,
      OP_RM_RD,
      OP_RM_WR,
      OP_CNT_DEC,
      OP_ROT_INIT,
      OP_ROT_RD,
      OP_ROT_WR,
      OP_IDX_CLEAR,
      OP_SRT_RDI,
      OP_SRT_LDI,
      OP_SRT_RDJ,
      OP_SRT_CMP,
      OP_SRT_WR1,
      OP_SRT_WR2,
      OP_DMP_RD,
      OP_DMP_OUT,
      OP_RESP
   } op_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      logic [2:0] mode;
      logic       full;
      logic       empty;
      logic       pos_bad;
      logic       rm_done;
      logic       rot_done;
      logic       sort_done;
      logic       j_done;
      logic       dump_last;
      logic       out_free;
   } dp_status_type;

endpackage

// ===== sv/bounded_list_engine.sv =====
// Top level of the bounded list engine: controller and datapath.
//
//   Channel | Ports                                         | Direction
//   req     | req_valid req_ready req_mode req_value req_amount | in
//   rsp     | rsp_valid rsp_ready rsp_element rsp_length rsp_status rsp_last | out
//
// One command is in work at a time; a new item is taken once the previous
// command's last result sits in the output register.
// A rotation runs amount single steps, one element moved per step; a dump
// reads the store once per element. Reset clears the length, head pointer and
// output valid flag only.
// A stalled result holds the output register and pauses the command.
module bounded_list_engine import ble_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_amount,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_element,
   output logic [4:0]         rsp_length,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   op_type        op;
   dp_status_type stat;

   ble_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .op        (op)
   );

   ble_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .req_mode    (req_mode),
      .req_value   (req_value),
      .req_amount  (req_amount),
      .rsp_ready   (rsp_ready),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_element (rsp_element),
      .rsp_length  (rsp_length),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // After an item is taken the engine is not ready in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("engine took a second item right after the first");

   // A dropped add or an ignored command gives a single zero result.
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_BAD)
      |-> rsp_last && rsp_element == 32'sd0)
      else $error("error result not final or carries an element");

   // A full status only appears when the list is at capacity.
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_length == 5'(CAPACITY))
      else $error("full status with a short list");
`endif

endmodule

// ===== sv/ble_ctrl.sv =====
// Controller state machine that sequences each command through the datapath.
module ble_ctrl import ble_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type stat,
   output op_type        op
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (stat.mode)
               MODE_ADD_FRONT, MODE_ADD_END: state_in = S_RESP;
               MODE_REMOVE:    state_in = stat.pos_bad ? S_RESP : S_RM_RD;
               MODE_SORT:      state_in = S_SRT_RDI;
               MODE_ROT_LEFT, MODE_ROT_RIGHT: state_in = stat.empty ? S_RESP : S_ROT_RD;
               default:        state_in = stat.empty ? S_RESP : S_DMP_RD;
            endcase
         end
         S_RM_RD:   state_in = stat.rm_done ? S_RESP : S_RM_WR;
         S_RM_WR:   state_in = S_RM_RD;
         S_ROT_RD:  state_in = stat.rot_done ? S_RESP : S_ROT_WR;
         S_ROT_WR:  state_in = S_ROT_RD;
         S_SRT_RDI: state_in = stat.sort_done ? S_RESP : S_SRT_LDI;
         S_SRT_LDI: state_in = S_SRT_RDJ;
         S_SRT_RDJ: state_in = stat.j_done ? S_SRT_WR1 : S_SRT_CMP;
         S_SRT_CMP: state_in = S_SRT_RDJ;
         S_SRT_WR1: state_in = S_SRT_WR2;
         S_SRT_WR2: state_in = S_SRT_RDI;
         S_DMP_RD:  state_in = S_DMP_OUT;
         S_DMP_OUT: begin
            if (stat.out_free) state_in = stat.dump_last ? S_IDLE : S_DMP_RD;
         end
         S_RESP: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      op        = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = OP_LATCH;
         end
         S_DISPATCH: begin
            case (stat.mode)
               MODE_ADD_FRONT: op = stat.full ? OP_SET_FULL : OP_ADD_FRONT;
               MODE_ADD_END:   op = stat.full ? OP_SET_FULL : OP_ADD_END;
               MODE_REMOVE:    op = stat.pos_bad ? OP_SET_BAD : OP_RM_INIT;
               MODE_SORT:      op = OP_IDX_CLEAR;
               MODE_ROT_LEFT, MODE_ROT_RIGHT: op = stat.empty ? OP_SET_BAD : OP_ROT_INIT;
               default:        op = OP_IDX_CLEAR;
            endcase
         end
         S_RM_RD:   op = stat.rm_done ? OP_CNT_DEC : OP_RM_RD;
         S_RM_WR:   op = OP_RM_WR;
         S_ROT_RD:  op = stat.rot_done ? OP_NONE : OP_ROT_RD;
         S_ROT_WR:  op = OP_ROT_WR;
         S_SRT_RDI: op = stat.sort_done ? OP_NONE : OP_SRT_RDI;
         S_SRT_LDI: op = OP_SRT_LDI;
         S_SRT_RDJ: op = stat.j_done ? OP_NONE : OP_SRT_RDJ;
         S_SRT_CMP: op = OP_SRT_CMP;
         S_SRT_WR1: op = OP_SRT_WR1;
         S_SRT_WR2: op = OP_SRT_WR2;
         S_DMP_RD:  op = OP_DMP_RD;
         S_DMP_OUT: op = stat.out_free ? OP_DMP_OUT : OP_NONE;
         S_RESP:    op = stat.out_free ? OP_RESP : OP_NONE;
         default:   op = OP_NONE;
      endcase
   end

endmodule

// ===== sv/ble_dpath.sv =====
// Datapath of the list engine: circular element store, indexes and result register.
module ble_dpath import ble_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  op_type             op,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_amount,
   input  logic               rsp_ready,
   output dp_status_type      stat,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_element,
   output logic [4:0]         rsp_length,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   localparam int PW  = $clog2(CAPACITY);
   localparam int PW1 = PW + 1;
   localparam int CW  = $clog2(CAPACITY + 1);

   // Element store, kept as a ring starting at the head pointer.
   logic signed [31:0] mem [CAPACITY];

   logic [PW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      i_ff, i_in, j_ff, j_in, m_ff, m_in;
   logic [2:0]         mode_ff, mode_in;
   logic signed [31:0] value_ff, value_in;
   logic [7:0]         amount_ff, amount_in;
   logic [7:0]         rot_ff, rot_in;
   logic [1:0]         st_ff, st_in;
   logic signed [31:0] vi_ff, vi_in, minv_ff, minv_in;
   logic signed [31:0] rdata_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_element_ff, rsp_element_in;
   logic [4:0]         rsp_length_ff, rsp_length_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               wr_en, rd_en;
   logic [PW-1:0]      wr_addr, rd_addr;
   logic signed [31:0] wr_data;
   logic [CW-1:0]      dmp_idx;
   logic               out_free;

   // Logical position to ring address.
   function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [CW-1:0] x);
      logic [PW1-1:0] s;
      s = PW1'(h) + PW1'(x);
      if (s >= PW1'(CAPACITY)) s = s - PW1'(CAPACITY);
      return s[PW-1:0];
   endfunction

   // Ring pointer one step back.
   function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] h);
      logic [PW-1:0] r;
      if (h == '0) r = PW'(CAPACITY - 1);
      else r = h - PW'(1);
      return r;
   endfunction

   // Ring pointer one step forward.
   function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] h);
      logic [PW-1:0] r;
      if (h == PW'(CAPACITY - 1)) r = '0;
      else r = h + PW'(1);
      return r;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign dmp_idx  = (mode_ff == MODE_DUMP_REV) ? (count_ff - CW'(1) - i_ff) : i_ff;

   // Status flags for the controller.
   always_comb begin
      stat.mode      = mode_ff;
      stat.full      = count_ff >= CW'(CAPACITY);
      stat.empty     = count_ff == '0;
      stat.pos_bad   = (amount_ff == 8'd0) || (9'(amount_ff) > 9'(count_ff));
      stat.rm_done   = (i_ff + CW'(1)) >= count_ff;
      stat.rot_done  = rot_ff == 8'd0;
      stat.sort_done = i_ff >= count_ff;
      stat.j_done    = j_ff >= count_ff;
      stat.dump_last = (i_ff + CW'(1)) == count_ff;
      stat.out_free  = out_free;
   end

   // Command decode: next values and store accesses.
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      m_in      = m_ff;
      mode_in   = mode_ff;
      value_in  = value_ff;
      amount_in = amount_ff;
      rot_in    = rot_ff;
      st_in     = st_ff;
      vi_in     = vi_ff;
      minv_in   = minv_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = value_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_element_in = rsp_element_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      case (op)
         OP_LATCH: begin
            mode_in   = req_mode;
            value_in  = req_value;
            amount_in = req_amount;
         end
         OP_ADD_FRONT: begin
            head_in  = ring_dec(head_ff);
            wr_en    = 1'b1;
            wr_addr  = ring_dec(head_ff);
            count_in = count_ff + CW'(1);
            st_in    = ST_OK;
         end
         OP_ADD_END: begin
            wr_en    = 1'b1;
            wr_addr  = phys(head_ff, count_ff);
            count_in = count_ff + CW'(1);
            st_in    = ST_OK;
         end
         OP_SET_FULL: st_in = ST_FULL;
         OP_SET_BAD:  st_in = ST_BAD;
         OP_RM_INIT: begin
            i_in  = CW'(amount_ff - 8'd1);
            st_in = ST_OK;
         end
         OP_RM_RD: begin
            rd_en   = 1'b1;
            rd_addr = phys(head_ff, i_ff + CW'(1));
         end
         OP_RM_WR: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, i_ff);
            wr_data = rdata_ff;
            i_in    = i_ff + CW'(1);
         end
         OP_CNT_DEC: count_in = count_ff - CW'(1);
         OP_ROT_INIT: begin
            rot_in = amount_ff;
            st_in  = ST_OK;
         end
         // One single-step rotation moves one element across the ring gap.
         OP_ROT_RD: begin
            rd_en   = 1'b1;
            rd_addr = (mode_ff == MODE_ROT_LEFT) ? head_ff
                                                 : phys(head_ff, count_ff - CW'(1));
         end
         OP_ROT_WR: begin
            wr_en   = 1'b1;
            wr_data = rdata_ff;
            rot_in  = rot_ff - 8'd1;
            if (mode_ff == MODE_ROT_LEFT) begin
               wr_addr = phys(head_ff, count_ff);
               head_in = ring_inc(head_ff);
            end else begin
               wr_addr = ring_dec(head_ff);
               head_in = ring_dec(head_ff);
            end
         end
         OP_IDX_CLEAR: begin
            i_in  = '0;
            st_in = ST_OK;
         end
         OP_SRT_RDI: begin
            rd_en   = 1'b1;
            rd_addr = phys(head_ff, i_ff);
         end
         OP_SRT_LDI: begin
            vi_in   = rdata_ff;
            minv_in = rdata_ff;
            m_in    = i_ff;
            j_in    = i_ff + CW'(1);
         end
         OP_SRT_RDJ: begin
            rd_en   = 1'b1;
            rd_addr = phys(head_ff, j_ff);
         end
         OP_SRT_CMP: begin
            if (rdata_ff < minv_ff) begin
               minv_in = rdata_ff;
               m_in    = j_ff;
            end
            j_in = j_ff + CW'(1);
         end
         OP_SRT_WR1: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, m_ff);
            wr_data = vi_ff;
         end
         OP_SRT_WR2: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, i_ff);
            wr_data = minv_ff;
            i_in    = i_ff + CW'(1);
         end
         OP_DMP_RD: begin
            rd_en   = 1'b1;
            rd_addr = phys(head_ff, dmp_idx);
         end
         OP_DMP_OUT: begin
            rsp_valid_in   = 1'b1;
            rsp_element_in = rdata_ff;
            rsp_length_in  = 5'(count_ff);
            rsp_status_in  = ST_OK;
            rsp_last_in    = (i_ff + CW'(1)) == count_ff;
            i_in           = i_ff + CW'(1);
         end
         OP_RESP: begin
            rsp_valid_in   = 1'b1;
            rsp_element_in = '0;
            rsp_length_in  = 5'(count_ff);
            rsp_status_in  = st_ff;
            rsp_last_in    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Element store with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      i_ff           <= i_in;
      j_ff           <= j_in;
      m_ff           <= m_in;
      mode_ff        <= mode_in;
      value_ff       <= value_in;
      amount_ff      <= amount_in;
      rot_ff         <= rot_in;
      st_ff          <= st_in;
      vi_ff          <= vi_in;
      minv_ff        <= minv_in;
      rsp_element_ff <= rsp_element_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_length  = rsp_length_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the bounded list engine: queue-fed driver, monitor and list predictor.
`timescale 1ns / 100ps

module tb_top import ble_pkg::*; ();

   localparam int CAP = 16;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
      logic [7:0]         amount;
   } cmd_type;

   typedef struct packed {
      logic signed [31:0] element;
      logic [4:0]         length;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_mode = '0;
   logic signed [31:0] req_value = '0;
   logic [7:0]         req_amount = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_element;
   logic [4:0]         rsp_length;
   logic [1:0]         rsp_status;
   logic               rsp_last;

   cmd_type     pending_cmds[$];
   rsp_type     expected_rsps[$];
   logic [31:0] list_vals[CAP];
   int          list_len = 0;
   int          fail_count = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 10;
   int          recv_idle_pct = 77;

   bounded_list_engine #(.CAPACITY(CAP)) dut (.*);

   // Clock generation.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predict the results of one command and update the list copy.
   task automatic predict_list(input cmd_type c);
      rsp_type     r;
      logic [1:0]  st;
      logic [31:0] t;
      int          n, m;
      st = ST_OK;
      case (c.mode)
         MODE_ADD_FRONT, MODE_ADD_END: begin
            if (list_len >= CAP) begin
               st = ST_FULL;
            end else if (c.mode == MODE_ADD_END) begin
               list_vals[list_len] = c.value;
               list_len++;
            end else begin
               for (int i = list_len; i > 0; i--) list_vals[i] = list_vals[i-1];
               list_vals[0] = c.value;
               list_len++;
            end
         end
         MODE_REMOVE: begin
            if (c.amount == 0 || c.amount > list_len) begin
               st = ST_BAD;
            end else begin
               for (int i = c.amount - 1; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
               list_len--;
            end
         end
         MODE_SORT: begin
            for (int i = 0; i < list_len; i++) begin
               m = i;
               for (int j = i + 1; j < list_len; j++)
                  if ($signed(list_vals[j]) < $signed(list_vals[m])) m = j;
               t = list_vals[i];
               list_vals[i] = list_vals[m];
               list_vals[m] = t;
            end
         end
         MODE_ROT_LEFT, MODE_ROT_RIGHT: begin
            if (list_len == 0) begin
               st = ST_BAD;
            end else begin
               n = c.amount % list_len;
               repeat (n) begin
                  if (c.mode == MODE_ROT_LEFT) begin
                     t = list_vals[0];
                     for (int i = 0; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
                     list_vals[list_len-1] = t;
                  end else begin
                     t = list_vals[list_len-1];
                     for (int i = list_len - 1; i > 0; i--) list_vals[i] = list_vals[i-1];
                     list_vals[0] = t;
                  end
               end
            end
         end
         default: begin
            // Dumps give one result per element, or a single one when empty.
            if (list_len == 0) begin
               r = '{element: '0, length: 5'd0, status: ST_OK, last: 1'b1};
               expected_rsps.push_back(r);
            end
            for (int i = 0; i < list_len; i++) begin
               r.element = list_vals[(c.mode == MODE_DUMP) ? i : list_len - 1 - i];
               r.length = list_len[4:0];
               r.status = ST_OK;
               r.last = (i + 1 == list_len);
               expected_rsps.push_back(r);
            end
            return;
         end
      endcase
      r = '{element: '0, length: list_len[4:0], status: st, last: 1'b1};
      expected_rsps.push_back(r);
   endtask

   // Driver: present items from the queue with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_mode <= pending_cmds[0].mode;
            req_value <= pending_cmds[0].value;
            req_amount <= pending_cmds[0].amount;
            predict_list(pending_cmds.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: random stalls and field checks against the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result item");
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_element !== e.element) begin
                  $error("element expected %0d got %0d", e.element, rsp_element);
                  fail_count++;
               end
               if (rsp_length !== e.length) begin
                  $error("length expected %0d got %0d", e.length, rsp_length);
                  fail_count++;
               end
               if (rsp_status !== e.status) begin
                  $error("status expected %0d got %0d", e.status, rsp_status);
                  fail_count++;
               end
               if (rsp_last !== e.last) begin
                  $error("last expected %0d got %0d", e.last, rsp_last);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL bounded_list_engine");
         $finish;
      end
   end

   function automatic cmd_type rand_cmd();
      cmd_type c;
      int      p;
      p = $urandom_range(99);
      // Favor adds so the list often fills; amounts mostly from 0 to CAP + 1.
      if (p < 40) c.mode = 3'($urandom_range(1));
      else c.mode = 3'($urandom_range(7));
      c.value = $urandom;
      if ($urandom_range(3) == 0) c.amount = 8'($urandom_range(255));
      else c.amount = 8'($urandom_range(CAP + 1));
      return c;
   endfunction

   task automatic add_cmd(input logic [2:0] m, input logic [31:0] v, input logic [7:0] a);
      pending_cmds.push_back('{mode: m, value: v, amount: a});
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // Directed: empty-list cases, extremes, full list and every mode.
      add_cmd(MODE_DUMP, 0, 0);
      add_cmd(MODE_ROT_LEFT, 0, 3);
      add_cmd(MODE_REMOVE, 0, 1);
      add_cmd(MODE_SORT, 0, 0);
      add_cmd(MODE_ADD_END, 32'h7fffffff, 0);
      add_cmd(MODE_ADD_FRONT, 32'h80000000, 255);
      add_cmd(MODE_ADD_END, 32'hffffffff, 0);
      add_cmd(MODE_REMOVE, 0, 0);
      add_cmd(MODE_REMOVE, 0, 4);
      add_cmd(MODE_ROT_RIGHT, 0, 0);
      add_cmd(MODE_ROT_LEFT, 0, 255);
      add_cmd(MODE_DUMP_REV, 0, 0);
      for (int i = 0; i < 14; i++) add_cmd(MODE_ADD_END, $urandom, 0);
      add_cmd(MODE_ADD_FRONT, 5, 0);
      add_cmd(MODE_SORT, 0, 0);
      add_cmd(MODE_DUMP, 0, 0);
      add_cmd(MODE_REMOVE, 0, 16);
      // Random phases with different idling.
      for (int ph = 0; ph < 3; ph++) begin
         for (int i = 0; i < 110; i++) pending_cmds.push_back(rand_cmd());
         wait (pending_cmds.size() == 0 && expected_rsps.size() == 0);
         repeat (200) @(posedge clock);
         send_idle_pct = (ph == 0) ? 77 : 0;
         recv_idle_pct = (ph == 0) ? 10 : 0;
      end
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("PASS bounded_list_engine");
      end else begin
         $display("FAIL bounded_list_engine");
      end
      $finish;
   end

endmodule
